// ===== rtl/buddy_block_allocator_unit_defines.svh =====
// assertion macros for the buddy block allocator unit
// used by the top level; expects clk and arst_n in scope
`ifndef BUDDY_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define BBAU_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("bbau assertion failed");

// next-cycle implication
`define BBAU_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("bbau assertion failed");

`endif

// ===== rtl/bbau_pkg.sv =====
// shared types and constants for the buddy block allocator unit
// no dependencies
package bbau_pkg;

	localparam int WORD_BITS  = 32;
	localparam int WBIT_W     = 5;
	localparam int SIZE_W     = 13;
	localparam int ADDR_W     = 14;
	localparam int STATUS_W   = 2;
	localparam int LEVEL_W    = 3;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 24;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOBLOCK = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TOOBIG  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOMEM   = 2'd3;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_CLEAR,
		CMD_LOAD,
		CMD_SCAN_RD,
		CMD_SCAN_CHK,
		CMD_SPLIT,
		CMD_WR_BUD_SET,
		CMD_ALLOC_OK,
		CMD_GL_CHK,
		CMD_RD_OWN,
		CMD_CHECK,
		CMD_RD_BUD,
		CMD_WR_BUD_CLR_UP,
		CMD_WR_OWN_SET,
		CMD_POST
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic in_op;
		logic in_reject;
		logic scan_hit;
		logic scan_last;
		logic gl_bad;
		logic ck_hit;
		logic k_top;
		logic k_eq_lvl;
		logic bud_free;
		logic out_busy;
	} dp_stat_t;

endpackage

// ===== rtl/bbau_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module bbau_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/bbau_ctrl.sv =====
// controller state machine of the buddy block allocator unit
// depends on bbau_pkg
module bbau_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  bbau_pkg::dp_stat_t stat,
	output bbau_pkg::cmd_t    cmd
);

	typedef enum logic [13:0] {
		S_CLEAR = 14'b00000000000001,
		S_IDLE  = 14'b00000000000010,
		S_SRD   = 14'b00000000000100,
		S_SCHK  = 14'b00000000001000,
		S_SPL   = 14'b00000000010000,
		S_SPW   = 14'b00000000100000,
		S_FGL   = 14'b00000001000000,
		S_FCK   = 14'b00000010000000,
		S_FCKD  = 14'b00000100000000,
		S_FMG   = 14'b00001000000000,
		S_FMGD  = 14'b00010000000000,
		S_FSET  = 14'b00100000000000,
		S_FSETW = 14'b01000000000000,
		S_POST  = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = bbau_pkg::CMD_NONE;
		case (state_q)
			S_CLEAR: begin
				cmd = bbau_pkg::CMD_CLEAR;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd = bbau_pkg::CMD_LOAD;
					if (stat.in_reject) state_d = S_POST;
					else if (stat.in_op) state_d = S_FGL;
					else state_d = S_SRD;
				end
			end
			S_SRD: begin
				cmd     = bbau_pkg::CMD_SCAN_RD;
				state_d = S_SCHK;
			end
			S_SCHK: begin
				cmd = bbau_pkg::CMD_SCAN_CHK;
				if (stat.scan_hit) state_d = S_SPL;
				else if (stat.scan_last) state_d = S_POST;
				else state_d = S_SRD;
			end
			S_SPL: begin
				if (stat.k_eq_lvl) begin
					cmd     = bbau_pkg::CMD_ALLOC_OK;
					state_d = S_POST;
				end else begin
					cmd     = bbau_pkg::CMD_SPLIT;
					state_d = S_SPW;
				end
			end
			S_SPW: begin
				cmd     = bbau_pkg::CMD_WR_BUD_SET;
				state_d = S_SPL;
			end
			S_FGL: begin
				cmd     = bbau_pkg::CMD_GL_CHK;
				state_d = stat.gl_bad ? S_POST : S_FCK;
			end
			S_FCK: begin
				cmd     = bbau_pkg::CMD_RD_OWN;
				state_d = S_FCKD;
			end
			S_FCKD: begin
				cmd = bbau_pkg::CMD_CHECK;
				if (stat.ck_hit) state_d = S_POST;
				else if (stat.k_top) state_d = S_FMG;
				else state_d = S_FCK;
			end
			S_FMG: begin
				if (stat.k_top) begin
					state_d = S_FSET;
				end else begin
					cmd     = bbau_pkg::CMD_RD_BUD;
					state_d = S_FMGD;
				end
			end
			S_FMGD: begin
				if (stat.bud_free) begin
					cmd     = bbau_pkg::CMD_WR_BUD_CLR_UP;
					state_d = S_FMG;
				end else begin
					state_d = S_FSET;
				end
			end
			S_FSET: begin
				cmd     = bbau_pkg::CMD_RD_OWN;
				state_d = S_FSETW;
			end
			S_FSETW: begin
				cmd     = bbau_pkg::CMD_WR_OWN_SET;
				state_d = S_POST;
			end
			S_POST: begin
				if (!stat.out_busy) begin
					cmd     = bbau_pkg::CMD_POST;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/bbau_dp.sv =====
// datapath of the buddy block allocator unit: free map, granted levels, result register
// depends on bbau_pkg and bbau_ram
module bbau_dp #(
	parameter int MIN_LOG      = 5,
	parameter int LEVEL_COUNT  = 8,
	parameter int PAGE_BYTES   = 4096,
	parameter int POOL_PAGES   = 4,
	parameter int HEADER_BYTES = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bbau_pkg::cmd_t                      cmd,
	output bbau_pkg::dp_stat_t                  stat,
	input  logic [bbau_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [bbau_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic [bbau_pkg::STATUS_W-1:0]       m_tuser
);

	localparam int TOP      = LEVEL_COUNT - 1;
	localparam int UNITS    = POOL_PAGES << TOP;
	localparam int U_W      = $clog2(UNITS);
	localparam int LV_W     = $clog2(LEVEL_COUNT);
	localparam int FM_BITS  = 2 * UNITS - ((2 * UNITS) >> LEVEL_COUNT);
	localparam int WB       = bbau_pkg::WORD_BITS;
	localparam int WBW      = bbau_pkg::WBIT_W;
	localparam int FM_DEPTH = (FM_BITS + WB - 1) / WB;
	localparam int WA_W     = FM_DEPTH > 1 ? $clog2(FM_DEPTH) : 1;
	localparam int IDX_W    = WA_W + WBW;
	localparam int SZW      = bbau_pkg::SIZE_W;
	localparam int AW       = bbau_pkg::ADDR_W;
	localparam int STW      = bbau_pkg::STATUS_W;
	localparam int LVO      = bbau_pkg::LEVEL_W;
	localparam int ODW      = bbau_pkg::OUT_DATA_W;

	function automatic logic [IDX_W-1:0] base_of(input logic [LV_W-1:0] k);
		return IDX_W'((2 * UNITS) - ((2 * UNITS) >> k));
	endfunction

	function automatic logic [IDX_W-1:0] oidx(input logic [LV_W-1:0] k,
		input logic [U_W-1:0] u);
		return base_of(k) + IDX_W'(u >> k);
	endfunction

	function automatic logic [IDX_W-1:0] bidx(input logic [LV_W-1:0] k,
		input logic [U_W-1:0] u);
		return base_of(k) + IDX_W'((u >> k) ^ U_W'(1));
	endfunction

	// registers
	logic [WA_W-1:0]  clr_q, scan_q;
	logic [LV_W-1:0]  lvl_q, k_q;
	logic [U_W-1:0]   u_q;
	logic [AW-1:0]    addr_q;
	logic [STW-1:0]   res_st_q;
	logic [AW-1:0]    res_addr_q;
	logic [LVO-1:0]   res_lvl_q;
	logic             out_valid_q;
	logic [STW-1:0]   out_st_q;
	logic [AW-1:0]    out_addr_q;
	logic [LVO-1:0]   out_lvl_q;

	// memories
	logic             fm_we;
	logic [WA_W-1:0]  fm_waddr, fm_raddr;
	logic [WB-1:0]    fm_wdata, fm_rdata;
	logic             gl_we;
	logic [U_W-1:0]   gl_waddr;
	logic [LV_W-1:0]  gl_rdata;

	// input decode
	logic [SZW-1:0]   in_size;
	logic [AW-1:0]    in_addr;
	logic [31:0]      total, start;
	logic [LV_W:0]    need_cnt;
	logic [IDX_W-1:0] need_base;
	logic             a_zero, a_big, f_bad;
	logic [U_W-1:0]   u_in;

	always_comb begin
		in_size  = s_tdata[SZW-1:0];
		in_addr  = s_tdata[SZW+AW-1:SZW];
		total    = 32'(in_size) + 32'(HEADER_BYTES);
		need_cnt = '0;
		for (int l = 0; l < LEVEL_COUNT; l++) begin
			if ((32'd1 << (MIN_LOG + l)) < total) need_cnt = need_cnt + 1'b1;
		end
		need_base = base_of(LV_W'(need_cnt));
		a_zero = (in_size == '0);
		a_big  = total > 32'(PAGE_BYTES);
		start  = 32'(in_addr) - 32'(HEADER_BYTES);
		f_bad  = (32'(in_addr) < 32'(HEADER_BYTES)) ||
			((start & ((32'd1 << MIN_LOG) - 32'd1)) != 32'd0) ||
			((start >> MIN_LOG) >= 32'(UNITS));
		u_in   = U_W'(start >> MIN_LOG);
	end

	// scan decode
	logic [WB-1:0]    scan_mask;
	logic [WBW-1:0]   hit_pos;
	logic             hit;
	logic [IDX_W-1:0] found_f, found_b;
	logic [LV_W-1:0]  found_k;
	logic [U_W-1:0]   found_u;
	logic [WB-1:0]    init_word;

	always_comb begin
		for (int i = 0; i < WB; i++) begin
			scan_mask[i] = ({scan_q, WBW'(i)} >= base_of(lvl_q)) &&
				(32'({scan_q, WBW'(i)}) < 32'(FM_BITS)) && fm_rdata[i];
			init_word[i] = ({clr_q, WBW'(i)} >= base_of(LV_W'(TOP))) &&
				(32'({clr_q, WBW'(i)}) < 32'(FM_BITS));
		end
		hit     = |scan_mask;
		hit_pos = '0;
		for (int i = WB - 1; i >= 0; i--) begin
			if (scan_mask[i]) hit_pos = WBW'(i);
		end
		found_f = {scan_q, hit_pos};
		found_k = '0;
		for (int l = 1; l < LEVEL_COUNT; l++) begin
			if (base_of(LV_W'(l)) <= found_f) found_k = found_k + 1'b1;
		end
		found_b = found_f - base_of(found_k);
		found_u = U_W'(32'(found_b) << found_k);
	end

	logic [IDX_W-1:0] own_i, bud_i, spl_i;
	logic [LV_W-1:0]  k_dn;
	logic             gl_bad;

	always_comb begin
		k_dn   = k_q - 1'b1;
		own_i  = oidx(k_q, u_q);
		bud_i  = bidx(k_q, u_q);
		spl_i  = bidx(k_dn, u_q);
		gl_bad = (32'(gl_rdata) >= 32'(LEVEL_COUNT)) ||
			((32'(u_q) & ((32'd1 << gl_rdata) - 32'd1)) != 32'd0);
	end

	// memory port selection
	always_comb begin
		fm_we    = 1'b0;
		fm_waddr = scan_q;
		fm_wdata = fm_rdata;
		fm_raddr = scan_q;
		case (cmd)
			bbau_pkg::CMD_CLEAR: begin
				fm_we    = 1'b1;
				fm_waddr = clr_q;
				fm_wdata = init_word;
			end
			bbau_pkg::CMD_SCAN_CHK: begin
				fm_we    = hit;
				fm_wdata = fm_rdata & ~(WB'(1) << hit_pos);
			end
			bbau_pkg::CMD_SPLIT: begin
				fm_raddr = spl_i[IDX_W-1:WBW];
			end
			bbau_pkg::CMD_WR_BUD_SET: begin
				fm_we    = 1'b1;
				fm_waddr = bud_i[IDX_W-1:WBW];
				fm_wdata = fm_rdata | (WB'(1) << bud_i[WBW-1:0]);
			end
			bbau_pkg::CMD_RD_OWN: begin
				fm_raddr = own_i[IDX_W-1:WBW];
			end
			bbau_pkg::CMD_RD_BUD: begin
				fm_raddr = bud_i[IDX_W-1:WBW];
			end
			bbau_pkg::CMD_WR_BUD_CLR_UP: begin
				fm_we    = 1'b1;
				fm_waddr = bud_i[IDX_W-1:WBW];
				fm_wdata = fm_rdata & ~(WB'(1) << bud_i[WBW-1:0]);
			end
			bbau_pkg::CMD_WR_OWN_SET: begin
				fm_we    = 1'b1;
				fm_waddr = own_i[IDX_W-1:WBW];
				fm_wdata = fm_rdata | (WB'(1) << own_i[WBW-1:0]);
			end
			default: begin
				fm_we = 1'b0;
			end
		endcase
		gl_we    = (cmd == bbau_pkg::CMD_SCAN_CHK) && hit;
		gl_waddr = found_u;
	end

	bbau_ram #(.WIDTH(WB), .DEPTH(FM_DEPTH)) u_free_map (
		.clk   (clk),
		.we    (fm_we),
		.waddr (fm_waddr),
		.wdata (fm_wdata),
		.raddr (fm_raddr),
		.rdata (fm_rdata)
	);

	bbau_ram #(.WIDTH(LV_W), .DEPTH(UNITS)) u_granted (
		.clk   (clk),
		.we    (gl_we),
		.waddr (gl_waddr),
		.wdata (lvl_q),
		.raddr (u_in),
		.rdata (gl_rdata)
	);

	// status to controller
	always_comb begin
		stat.clr_last  = (clr_q == WA_W'(FM_DEPTH - 1));
		stat.in_op     = s_tuser;
		stat.in_reject = s_tuser ? f_bad : (a_zero || a_big);
		stat.scan_hit  = hit;
		stat.scan_last = (scan_q == WA_W'(FM_DEPTH - 1));
		stat.gl_bad    = gl_bad;
		stat.ck_hit    = fm_rdata[own_i[WBW-1:0]];
		stat.k_top     = (k_q == LV_W'(TOP));
		stat.k_eq_lvl  = (k_q == lvl_q);
		stat.bud_free  = fm_rdata[bud_i[WBW-1:0]];
		stat.out_busy  = out_valid_q && !m_tready;
	end

	// clear pointer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd == bbau_pkg::CMD_CLEAR) clr_q <= clr_q + 1'b1;
			if (cmd == bbau_pkg::CMD_POST) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// working and result registers
	always_ff @(posedge clk) begin
		case (cmd)
			bbau_pkg::CMD_LOAD: begin
				lvl_q      <= LV_W'(need_cnt);
				addr_q     <= in_addr;
				u_q        <= u_in;
				scan_q     <= need_base[IDX_W-1:WBW];
				res_addr_q <= '0;
				res_lvl_q  <= '0;
				if (s_tuser || a_zero) res_st_q <= bbau_pkg::ST_NOBLOCK;
				else res_st_q <= bbau_pkg::ST_TOOBIG;
			end
			bbau_pkg::CMD_SCAN_CHK: begin
				if (hit) begin
					u_q <= found_u;
					k_q <= found_k;
				end else if (scan_q == WA_W'(FM_DEPTH - 1)) begin
					res_st_q   <= bbau_pkg::ST_NOMEM;
					res_addr_q <= '0;
					res_lvl_q  <= '0;
				end else begin
					scan_q <= scan_q + 1'b1;
				end
			end
			bbau_pkg::CMD_SPLIT: begin
				k_q <= k_dn;
			end
			bbau_pkg::CMD_ALLOC_OK: begin
				res_st_q   <= bbau_pkg::ST_OK;
				res_addr_q <= AW'((32'(u_q) << MIN_LOG) + 32'(HEADER_BYTES));
				res_lvl_q  <= LVO'(lvl_q);
			end
			bbau_pkg::CMD_GL_CHK: begin
				k_q   <= gl_rdata;
				lvl_q <= gl_rdata;
				res_st_q   <= bbau_pkg::ST_NOBLOCK;
				res_addr_q <= '0;
				res_lvl_q  <= '0;
			end
			bbau_pkg::CMD_CHECK: begin
				if (!fm_rdata[own_i[WBW-1:0]]) begin
					if (k_q == LV_W'(TOP)) k_q <= lvl_q;
					else k_q <= k_q + 1'b1;
				end
			end
			bbau_pkg::CMD_WR_BUD_CLR_UP: begin
				u_q <= u_q & ~(U_W'(1) << k_q);
				k_q <= k_q + 1'b1;
			end
			bbau_pkg::CMD_WR_OWN_SET: begin
				res_st_q   <= bbau_pkg::ST_OK;
				res_addr_q <= addr_q;
				res_lvl_q  <= LVO'(k_q);
			end
			bbau_pkg::CMD_POST: begin
				out_st_q   <= res_st_q;
				out_addr_q <= res_addr_q;
				out_lvl_q  <= res_lvl_q;
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_st_q;
	assign m_tdata  = ODW'({out_lvl_q, out_addr_q});

endmodule

// ===== rtl/buddy_block_allocator_unit.sv =====
// Buddy block allocator unit, top level: controller, datapath and assertions.
// Depends on bbau_pkg, bbau_ram, bbau_ctrl, bbau_dp and the defines header.
//
// Input stream (s_*): one request per transfer. s_tuser is the op (0 allocate,
// 1 free); s_tdata holds request_bytes [12:0] and release_address [26:13].
// Output stream (m_*): one result per request, in order. m_tuser is the status;
// m_tdata holds payload_address [13:0] and block_level [16:14].
// After reset the free map is initialized by a pass of one word per cycle
// over its ceil(free map bits / 32) words (32 at the default sizes); no request
// is taken until it ends. One request is worked on at a time.
// Allocate scans free-map words from the wanted level upward and splits the
// found block down to the wanted level; a rejected request goes straight to
// its result. Free reads the granted level, checks for an enclosing free block,
// merges with free buddies up to a busy buddy or the top level, then sets its bit.
// The result sits in an output register; if m_tready is low the unit finishes
// the next request and then waits to post its result until the register frees.
`include "buddy_block_allocator_unit_defines.svh"

module buddy_block_allocator_unit #(
	parameter int MIN_LOG      = 5,
	parameter int LEVEL_COUNT  = 8,
	parameter int PAGE_BYTES   = 4096,
	parameter int POOL_PAGES   = 4,
	parameter int HEADER_BYTES = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// request_bytes, release_address, zero fill
	input  logic [bbau_pkg::IN_DATA_W-1:0]  s_tdata,
	// op
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// payload_address, block_level, zero fill
	output logic [bbau_pkg::OUT_DATA_W-1:0] m_tdata,
	// status
	output logic [bbau_pkg::STATUS_W-1:0]   m_tuser
);

	bbau_pkg::cmd_t     cmd;
	bbau_pkg::dp_stat_t stat;

	bbau_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bbau_dp #(
		.MIN_LOG      (MIN_LOG),
		.LEVEL_COUNT  (LEVEL_COUNT),
		.PAGE_BYTES   (PAGE_BYTES),
		.POOL_PAGES   (POOL_PAGES),
		.HEADER_BYTES (HEADER_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	`BBAU_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
	`BBAU_ASSERT_NEXT(a_post_gives_valid, cmd == bbau_pkg::CMD_POST, m_tvalid)
	`BBAU_ASSERT_NOW(a_no_post_over_stall, m_tvalid && !m_tready, cmd != bbau_pkg::CMD_POST)

endmodule

// ===== tb/buddy_block_allocator_unit_test.sv =====
// testbench for the buddy block allocator unit: directed and random allocate/free
// requests checked against an in-bench allocator model; depends on bbau_pkg and the rtl
module buddy_block_allocator_unit_test;

	localparam int LVLS = 8;
	localparam int TOP = LVLS - 1;
	localparam int UNITS = 512;
	localparam int HDR = 24;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [bbau_pkg::STATUS_W-1:0] status;
		logic [bbau_pkg::ADDR_W-1:0] addr;
		logic [bbau_pkg::LEVEL_W-1:0] level;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [bbau_pkg::IN_DATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [bbau_pkg::OUT_DATA_W-1:0] m_tdata;
	logic [bbau_pkg::STATUS_W-1:0] m_tuser;

	bit free_bits [LVLS][UNITS];
	int granted [UNITS];
	bit was_granted [UNITS];
	int live_addrs [$];
	result_t pending_results [$];
	int errors = 0;
	longint cycles = 0;
	bit hold_off = 1'b0;
	bit sink_stalls = 1'b1;

	buddy_block_allocator_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic result_t predict_alloc(int size);
		result_t res;
		int want, k, u, fu, fk;
		bit found;
		res = '0;
		found = 1'b0;
		if (size == 0) begin
			res.status = bbau_pkg::ST_NOBLOCK;
			return res;
		end
		want = 0;
		while (want < LVLS && (32 << want) < size + HDR) want++;
		if (want >= LVLS) begin
			res.status = bbau_pkg::ST_TOOBIG;
			return res;
		end
		for (k = want; k < LVLS && !found; k++)
			for (u = 0; u < UNITS; u += (1 << k))
				if (free_bits[k][u]) begin
					found = 1'b1;
					fu = u;
					fk = k;
					break;
				end
		if (!found) begin
			res.status = bbau_pkg::ST_NOMEM;
			return res;
		end
		free_bits[fk][fu] = 1'b0;
		while (fk > want) begin
			fk--;
			free_bits[fk][fu + (1 << fk)] = 1'b1;
		end
		granted[fu] = want;
		was_granted[fu] = 1'b1;
		res.status = bbau_pkg::ST_OK;
		res.addr = bbau_pkg::ADDR_W'((fu << 5) + HDR);
		res.level = bbau_pkg::LEVEL_W'(want);
		return res;
	endfunction

	function automatic result_t predict_release(int addr);
		result_t res;
		int start, u, lvl, k;
		res = '0;
		res.status = bbau_pkg::ST_NOBLOCK;
		if (addr < HDR) return res;
		start = addr - HDR;
		if ((start & 31) != 0 || (start >> 5) >= UNITS) return res;
		u = start >> 5;
		lvl = granted[u];
		if ((u & ((1 << lvl) - 1)) != 0) return res;
		for (k = lvl; k < LVLS; k++)
			if (free_bits[k][u & ~((1 << k) - 1)]) return res;
		while (lvl < TOP) begin
			if (!free_bits[lvl][u ^ (1 << lvl)]) break;
			free_bits[lvl][u ^ (1 << lvl)] = 1'b0;
			u &= ~(1 << lvl);
			lvl++;
		end
		free_bits[lvl][u] = 1'b1;
		res.status = bbau_pkg::ST_OK;
		res.addr = bbau_pkg::ADDR_W'(addr);
		res.level = bbau_pkg::LEVEL_W'(lvl);
		return res;
	endfunction

	// never frees a unit that was not granted
	function automatic bit release_legal(int addr);
		int start;
		if (addr < HDR) return 1'b1;
		start = addr - HDR;
		if ((start & 31) != 0 || (start >> 5) >= UNITS) return 1'b1;
		return was_granted[start >> 5];
	endfunction

	// valid stays high between back-to-back requests and drops only over a gap
	task automatic send_request(bit op, int size, int addr);
		result_t res;
		int g;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {5'd0, 14'(addr), 13'(size)};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (op) res = predict_release(addr);
		else res = predict_alloc(size);
		pending_results.push_back(res);
		if (op == 1'b0 && res.status == bbau_pkg::ST_OK) live_addrs.push_back(int'(res.addr));
		@(negedge clk);
	endtask

	task automatic alloc(int size);
		send_request(1'b0, size, $urandom_range(0, 16383));
	endtask

	task automatic release_addr(int addr);
		int i;
		addr = addr & 16383;
		if (!release_legal(addr)) return;
		for (i = 0; i < live_addrs.size(); i++)
			if (live_addrs[i] == addr) begin
				live_addrs.delete(i);
				break;
			end
		send_request(1'b1, $urandom_range(0, 8191), addr);
	endtask

	task automatic release_random_live();
		int i;
		if (live_addrs.size() == 0) return;
		i = $urandom_range(0, live_addrs.size() - 1);
		release_addr(live_addrs[i]);
	endtask

	// result sink
	always @(negedge clk) begin
		if (hold_off) m_tready <= 1'b0;
		else if (sink_stalls) m_tready <= ($urandom_range(0, 99) < 70);
		else m_tready <= 1'b1;
	end

	always @(posedge clk) begin
		result_t exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result status %0d tdata %h", $time, m_tuser, m_tdata);
				errors++;
			end else begin
				exp_res = pending_results.pop_front();
				if (m_tuser !== exp_res.status) begin
					$display("%0t status expected %0d actual %0d", $time,
						exp_res.status, m_tuser);
					errors++;
				end
				if (m_tdata[13:0] !== exp_res.addr) begin
					$display("%0t address expected %0d actual %0d", $time,
						exp_res.addr, m_tdata[13:0]);
					errors++;
				end
				if (m_tdata[16:14] !== exp_res.level) begin
					$display("%0t level expected %0d actual %0d", $time,
						exp_res.level, m_tdata[16:14]);
					errors++;
				end
				if (m_tdata[23:17] !== 7'd0) begin
					$display("%0t fill expected 0 actual %h", $time, m_tdata[23:17]);
					errors++;
				end
			end
		end
	end

	task automatic test_special_cases();
		alloc(0);
		alloc(4096);
		alloc(8191);
		alloc(4073);
		alloc(4072);
		alloc(1);
		alloc(8);
		alloc(9);
		release_addr(0);
		release_addr(23);
		release_addr(25);
		release_addr(16383);
		release_addr(24 + 512 * 32);
		release_addr(4096 + 24);
		release_addr(4096 + 24);
		release_addr(4096 + 24 + 64);
		alloc(2000);
		alloc(4072);
		alloc(4072);
		alloc(1);
		while (live_addrs.size() > 0) release_random_live();
	endtask

	task automatic test_fill_and_drain();
		int i;
		for (i = 0; i < 140; i++) alloc($urandom_range(1, 8));
		while (live_addrs.size() > 0) release_random_live();
	endtask

	task automatic test_random_mix(int count);
		int i, r, a;
		for (i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				if ($urandom_range(0, 3) == 0) alloc($urandom_range(0, 8191));
				else alloc($urandom_range(1, 1 << $urandom_range(3, 12)));
			end else if (r < 85) begin
				release_random_live();
			end else if (r < 92 && live_addrs.size() > 0) begin
				a = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
				a = a + (32 << $urandom_range(0, 6));
				release_addr(a);
			end else begin
				release_addr($urandom_range(0, 16383));
			end
		end
	endtask

	task automatic test_output_backpressure();
		int i;
		fork
			begin
				hold_off = 1'b1;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			for (i = 0; i < 20; i++) alloc($urandom_range(1, 200));
		join
		while (live_addrs.size() > 0) release_random_live();
	endtask

	initial begin
		int guard;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		foreach (free_bits[k, u]) free_bits[k][u] = 1'b0;
		foreach (granted[u]) begin
			granted[u] = 0;
			was_granted[u] = 1'b0;
		end
		for (int p = 0; p < 4; p++) free_bits[TOP][p * 128] = 1'b1;
		test_special_cases();
		test_output_backpressure();
		test_fill_and_drain();
		sink_stalls = 1'b0;
		test_random_mix(300);
		sink_stalls = 1'b1;
		test_random_mix(900);
		s_tvalid <= 1'b0;
		guard = 0;
		while (pending_results.size() > 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (200) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

// ===== buddy_block_allocator_unit.f =====
+incdir+rtl
rtl/bbau_pkg.sv
rtl/bbau_ram.sv
rtl/bbau_ctrl.sv
rtl/bbau_dp.sv
rtl/buddy_block_allocator_unit.sv
tb/buddy_block_allocator_unit_test.sv
